// ----- rtl/grse_pkg.sv -----
// Shared types, constants and helper functions for the glyph row shadow expander.
// No dependencies; every other file imports this package.
package grse_pkg;

  localparam int unsigned GLYPH_ROWS = 15;
  localparam int unsigned OUT_COLS   = 12;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned PIX_W      = 4;
  localparam int unsigned WORD_W     = 16;

  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(GLYPH_ROWS - 1);
  localparam logic [ROW_W-1:0] EXTRA_ROW = ROW_W'(GLYPH_ROWS);

  localparam logic [PIX_W-1:0] PIX_BLANK  = 4'd0;
  localparam logic [PIX_W-1:0] PIX_INK    = 4'd2;
  localparam logic [PIX_W-1:0] PIX_SHADOW = 4'd11;

  // One row of pixels; a column is ink, shadow, or blank when neither bit is set.
  typedef struct packed {
    logic [OUT_COLS-1:0] ink;
    logic [OUT_COLS-1:0] shade;
  } row_px_t;

  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [ROW_W-1:0]  row;
    logic              done;
  } result_t;

  // Swap the bytes and squeeze 15 source columns into 12 output columns.
  function automatic logic [OUT_COLS-1:0] squeeze_row(input logic [15:0] raw);
    logic [15:0] sw;
    logic [14:0] s;
    logic [OUT_COLS-1:0] c;
    sw = {raw[7:0], raw[15:8]};
    for (int k = 0; k < 15; k++) begin
      s[k] = sw[15-k];
    end
    c[0]  = s[0];
    c[1]  = s[1] | s[2];
    c[2]  = s[3];
    c[3]  = s[4];
    c[4]  = s[5] | s[6];
    c[5]  = s[7];
    c[6]  = s[8] | s[9];
    c[7]  = s[10];
    c[8]  = s[11];
    c[9]  = s[12] | s[13];
    c[10] = s[14];
    c[11] = 1'b0;
    return c;
  endfunction

  // Expand a pixel row into 48 bits of nibbles, column j at bits 4*j.
  function automatic logic [3*WORD_W-1:0] pack_row(input row_px_t px);
    logic [3*WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < OUT_COLS; k++) begin
      if (px.ink[k]) begin
        w[PIX_W*k +: PIX_W] = PIX_INK;
      end else if (px.shade[k]) begin
        w[PIX_W*k +: PIX_W] = PIX_SHADOW;
      end else begin
        w[PIX_W*k +: PIX_W] = PIX_BLANK;
      end
    end
    return w;
  endfunction

endpackage

// ----- rtl/glyph_row_shadow_expander_unit.sv -----
// A row transaction is held in the input register, then shaded and loaded into the result register;
// the extra shadow row of a glyph leaves the pending slot once its last row is taken.
// Throughput: one row per cycle while out_ready_i is high, except that a glyph's pending extra shadow
// row holds the next row back, set by the single result register and its one pending slot.
// Reset (rst_ni low, asynchronous): row count, carry, previous row and all valids clear.
// Depends on grse_pkg, grse_row_shade, grse_extra_row and grse_out_buf.
module glyph_row_shadow_expander_unit import grse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       row_bits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] pix_word0_o,
  output logic [WORD_W-1:0] pix_word1_o,
  output logic [WORD_W-1:0] pix_word2_o,
  output logic [ROW_W-1:0]  out_row_o,
  output logic              glyph_done_o
);

  // Input register
  logic        in_v_q, in_v_d;
  logic [15:0] row_q;
  logic        in_fire;
  logic        advance;
  logic        can_load;

  // Glyph state
  logic [ROW_W-1:0] cnt_q, cnt_d;
  row_px_t          prev_q, prev_d;
  logic             carry_q, carry_d;

  // Shading results
  logic [OUT_COLS-1:0] cols;
  row_px_t             px;
  row_px_t             extra;
  logic                carry_nxt;
  logic                later;
  logic                last;
  logic [3*WORD_W-1:0] px_words;
  logic [3*WORD_W-1:0] extra_words;
  result_t             row_res;
  result_t             ext_res;
  result_t             out_res;

  // Take a new transaction whenever the input register is empty or moves on this cycle.
  assign advance    = in_v_q && can_load;
  assign in_ready_o = !in_v_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_v_d = in_v_q;
    if (in_fire) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q <= row_bits_i;
    end
  end

  // The first row has nothing above it; the last row also spawns the shadow row.
  assign later = (cnt_q != '0);
  assign last  = (cnt_q >= LAST_ROW);
  assign cols  = squeeze_row(row_q);

  grse_row_shade u_shade (
    .cols_i  (cols),
    .prev_i  (prev_q),
    .later_i (later),
    .carry_i (carry_q),
    .px_o    (px),
    .carry_o (carry_nxt)
  );

  grse_extra_row u_extra (
    .last_i  (px),
    .extra_o (extra)
  );

  assign px_words    = pack_row(px);
  assign extra_words = pack_row(extra);

  always_comb begin
    row_res.word0 = px_words[WORD_W-1:0];
    row_res.word1 = px_words[2*WORD_W-1:WORD_W];
    row_res.word2 = px_words[3*WORD_W-1:2*WORD_W];
    row_res.row   = cnt_q;
    row_res.done  = 1'b0;
    ext_res.word0 = extra_words[WORD_W-1:0];
    ext_res.word1 = extra_words[2*WORD_W-1:WORD_W];
    ext_res.word2 = extra_words[3*WORD_W-1:2*WORD_W];
    ext_res.row   = EXTRA_ROW;
    ext_res.done  = 1'b1;
  end

  // Advance the glyph state only when the row leaves for the result register.
  always_comb begin
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    carry_d = carry_q;
    if (advance) begin
      prev_d = px;
      if (last) begin
        cnt_d   = '0;
        carry_d = 1'b0;
      end else begin
        cnt_d   = cnt_q + ROW_W'(1);
        carry_d = carry_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prev_q  <= '0;
      carry_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      carry_q <= carry_d;
    end
  end

  grse_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .row_i       (row_res),
    .ext_en_i    (last),
    .ext_i       (ext_res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign pix_word0_o  = out_res.word0;
  assign pix_word1_o  = out_res.word1;
  assign pix_word2_o  = out_res.word2;
  assign out_row_o    = out_res.row;
  assign glyph_done_o = out_res.done;

endmodule

// ----- rtl/grse_row_shade.sv -----
// Shading of one glyph row: ink from the squeezed columns, shadow from left and above.
// Depends on grse_pkg.
module grse_row_shade import grse_pkg::*; (
  input  logic [OUT_COLS-1:0] cols_i,
  input  row_px_t             prev_i,
  input  logic                later_i,
  input  logic                carry_i,
  output row_px_t             px_o,
  output logic                carry_o
);

  logic [OUT_COLS-1:0] left_ink;
  logic                carry;

  assign left_ink = {cols_i[OUT_COLS-2:0], 1'b0};

  // Carry tracks the last blank column's above-is-ink; it holds across ink columns.
  always_comb begin
    carry       = carry_i;
    px_o.ink    = cols_i;
    px_o.shade  = '0;
    for (int k = 0; k < OUT_COLS; k++) begin
      if (!cols_i[k]) begin
        if (left_ink[k]) begin
          px_o.shade[k] = 1'b1;
        end
        if (later_i) begin
          if (k != 0 && prev_i.shade[k] && carry) begin
            px_o.shade[k] = 1'b1;
          end
          if (prev_i.ink[k]) begin
            px_o.shade[k] = 1'b1;
          end
          carry = prev_i.ink[k];
        end
      end
    end
    carry_o = carry;
  end

endmodule

// ----- rtl/grse_extra_row.sv -----
// Builds the shadow-only row that closes a glyph from its last row.
// Depends on grse_pkg.
module grse_extra_row import grse_pkg::*; (
  input  row_px_t last_i,
  output row_px_t extra_o
);

  logic [OUT_COLS-1:0] left_ink;

  assign left_ink = {last_i.ink[OUT_COLS-2:0], 1'b0};
  // No ink in the shadow row; shadow under ink and under shadow that trails ink.
  assign extra_o  = {{OUT_COLS{1'b0}}, last_i.ink | (last_i.shade & left_ink)};

endmodule

// ----- rtl/grse_out_buf.sv -----
// Result register plus one pending slot for the extra shadow row.
// Depends on grse_pkg.
module grse_out_buf import grse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t row_i,
  input  logic    ext_en_i,
  input  result_t ext_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    out_v_q, out_v_d;
  logic    ext_v_q, ext_v_d;
  result_t out_q, out_d;
  result_t ext_q, ext_d;
  logic    out_free;

  assign out_free   = !out_v_q || out_ready_i;
  assign can_load_o = !ext_v_q && out_free;

  always_comb begin
    out_v_d = out_v_q;
    ext_v_d = ext_v_q;
    out_d   = out_q;
    ext_d   = ext_q;
    if (ext_v_q && out_free) begin
      out_v_d = 1'b1;
      out_d   = ext_q;
      ext_v_d = 1'b0;
    end else if (load_i) begin
      out_v_d = 1'b1;
      out_d   = row_i;
      ext_v_d = ext_en_i;
      ext_d   = ext_i;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      ext_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      ext_v_q <= ext_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    ext_q <= ext_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/grse_checker.sv -----
// Port-level checks for the glyph row shadow expander, bound to the top level.
// Depends on grse_pkg and glyph_row_shadow_expander_unit.
module grse_checker import grse_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [15:0]       row_bits_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [WORD_W-1:0] pix_word0_o,
  input logic [WORD_W-1:0] pix_word1_o,
  input logic [WORD_W-1:0] pix_word2_o,
  input logic [ROW_W-1:0]  out_row_o,
  input logic              glyph_done_o
);

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pix_word0_o)
      && $stable(pix_word1_o) && $stable(pix_word2_o) && $stable(out_row_o)
      && $stable(glyph_done_o))
    else $error("stalled result changed");

  // The closing flag and the extra row number go together.
  a_done_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (glyph_done_o == (out_row_o == EXTRA_ROW)))
    else $error("glyph_done does not match row number");

  // The shadow row follows the last glyph row at once.
  a_extra_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !glyph_done_o && out_row_o == LAST_ROW |=> out_valid_o && glyph_done_o)
    else $error("extra shadow row did not follow the last row");

  // After a glyph closes, the next result starts a new glyph.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && glyph_done_o |=> !out_valid_o || out_row_o == '0)
    else $error("new glyph did not start at row zero");

endmodule

bind glyph_row_shadow_expander_unit grse_checker u_grse_checker (.*);
